[sv/quadrature_encoder_detent_decoder_unit_assert.svh]
// Assertion macros shared by the encoder decoder modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef QUADRATURE_ENCODER_DETENT_DECODER_UNIT_ASSERT_SVH
`define QUADRATURE_ENCODER_DETENT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define QEDD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qedd: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define QEDD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qedd: next-cycle check failed");

`endif

[sv/qedd_pkg.sv]
`default_nettype none

package qedd_pkg;

  // Sizes of the encoder set and of the item fields.
  localparam int ENCODER_COUNT = 4;
  localparam int IDX_W         = 2;
  localparam int NUMBER_W      = 3;
  localparam int TIME_W        = 32;
  localparam int DEB_W         = 8;
  localparam int SPD_W         = 4;
  localparam int ACC_W         = 4;
  localparam int SUM_W         = ACC_W + 1;
  localparam int STEP_W        = 2;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_DETENT = 2'd1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd15;
  localparam logic [SPD_W-1:0] STEPS_RESET    = 4'd4;
  localparam logic [SPD_W-1:0] STEPS_MIN      = 4'd1;
  localparam logic [SPD_W-1:0] STEPS_MAX      = 4'd8;

  // Step for each (old phase, new phase) pair, indexed by {old, new}.
  localparam logic signed [STEP_W-1:0] TRANSITION_STEP [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  // Live configuration as seen by the back end.
  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic [SPD_W-1:0] steps;
  } cfg_t;

  // Classified sample waiting between the front and the back end.
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic                hit;
    logic [1:0]          phase;
    logic                raw;
    logic [TIME_W-1:0]   now_ms;
    logic [NUMBER_W-1:0] number;
  } item_t;

  // Finished result word.
  typedef struct packed {
    logic [NUMBER_W-1:0]      number;
    logic signed [STEP_W-1:0] step;
    logic                     changed;
    logic                     pressed;
  } result_t;

endpackage

`default_nettype wire

[sv/qedd_front.sv]
`default_nettype none

module qedd_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [qedd_pkg::IDX_W-1:0]  encoder_index,
  input  wire logic                    phase_a,
  input  wire logic                    phase_b,
  input  wire logic                    button_raw,
  input  wire logic [qedd_pkg::TIME_W-1:0] now_ms,
  output logic                         head_valid,
  input  wire logic                    head_ready,
  output qedd_pkg::item_t              head
);
  import qedd_pkg::*;

  `include "quadrature_encoder_detent_decoder_unit_assert.svh"

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      word_in;
  logic       accept;
  logic       fq_pop;

  // Classify the incoming sample: encoder check, phase code and report number.
  always_comb begin
    word_in.idx    = encoder_index;
    word_in.hit    = (int'(encoder_index) < ENCODER_COUNT);
    word_in.phase  = {phase_a, phase_b};
    word_in.raw    = button_raw;
    word_in.now_ms = now_ms;
    word_in.number = {1'b0, encoder_index} + NUMBER_W'(1);
  end

  // Handshakes on both sides of the two-entry queue.
  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];
  assign fq_pop     = head_valid && head_ready;

  // Queue storage; the words themselves need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= word_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (fq_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (accept && !fq_pop) begin
        count <= count + 2'd1;
      end else if (fq_pop && !accept) begin
        count <= count - 2'd1;
      end
    end
  end

  `QEDD_ASSERT_IMPL(a_count_bound, 1'b1, count <= 2'd2)
  `QEDD_ASSERT_NEXT(a_push_grows, accept && !fq_pop, count == $past(count) + 2'd1)
  `QEDD_ASSERT_NEXT(a_full_holds, full && !fq_pop, full)

endmodule

`default_nettype wire

[sv/qedd_back.sv]
`default_nettype none

module qedd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire qedd_pkg::cfg_t  cfg,
  input  wire logic            head_valid,
  output logic                 head_ready,
  input  wire qedd_pkg::item_t head,
  output logic                 empty,
  input  wire logic            pop,
  output qedd_pkg::result_t    res_head
);
  import qedd_pkg::*;

  `include "quadrature_encoder_detent_decoder_unit_assert.svh"

  // Per-encoder state.
  logic [1:0]              phase_mem  [ENCODER_COUNT];
  logic signed [ACC_W-1:0] acc_mem    [ENCODER_COUNT];
  logic                    stable_mem [ENCODER_COUNT];
  logic                    last_raw   [ENCODER_COUNT];
  logic [TIME_W-1:0]       change_time[ENCODER_COUNT];

  // Output queue.
  result_t    oq [2];
  logic       oq_wr;
  logic       oq_rd;
  logic [1:0] oq_count;

  logic                     take;
  logic                     oq_pop;
  logic [3:0]               tix;
  logic signed [STEP_W-1:0] delta;
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [SUM_W-1:0]  spd;
  logic signed [SUM_W-1:0]  acc_adj;
  logic signed [STEP_W-1:0] detent;
  logic                     raw_diff;
  logic [TIME_W-1:0]        time_base;
  logic [TIME_W-1:0]        elapsed;
  logic                     settled;
  logic                     changed;
  logic                     pressed_next;
  result_t                  res;

  // An item is taken whenever the output queue has room.
  assign head_ready = (oq_count != 2'd2);
  assign take       = head_valid && head_ready;

  // Quadrature step and detent accumulation.
  always_comb begin
    tix     = {phase_mem[head.idx], head.phase};
    delta   = TRANSITION_STEP[tix];
    acc_sum = {acc_mem[head.idx][ACC_W-1], acc_mem[head.idx]}
              + {{(SUM_W-STEP_W){delta[STEP_W-1]}}, delta};
    spd     = {1'b0, cfg.steps};
    if (acc_sum >= spd) begin
      acc_adj = acc_sum - spd;
      detent  = 2'sd1;
    end else if (acc_sum <= -spd) begin
      acc_adj = acc_sum + spd;
      detent  = -2'sd1;
    end else begin
      acc_adj = acc_sum;
      detent  = 2'sd0;
    end
  end

  // Button debounce against the time of the last raw change.
  always_comb begin
    raw_diff     = (head.raw != last_raw[head.idx]);
    time_base    = raw_diff ? head.now_ms : change_time[head.idx];
    elapsed      = head.now_ms - time_base;
    settled      = (elapsed >= {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms});
    changed      = head.hit && settled && (head.raw != stable_mem[head.idx]);
    pressed_next = changed ? head.raw : stable_mem[head.idx];
  end

  // Result word; a sample for an absent encoder reports its number with step, changed and pressed all zero.
  always_comb begin
    res.number  = head.number;
    res.step    = head.hit ? detent : 2'sd0;
    res.changed = changed;
    res.pressed = head.hit && pressed_next;
  end

  // State update for the encoder named by the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENCODER_COUNT; i++) begin
        phase_mem[i]   <= 2'd0;
        acc_mem[i]     <= '0;
        stable_mem[i]  <= 1'b0;
        last_raw[i]    <= 1'b0;
        change_time[i] <= '0;
      end
    end else if (take && head.hit) begin
      phase_mem[head.idx]  <= head.phase;
      acc_mem[head.idx]    <= acc_adj[ACC_W-1:0];
      stable_mem[head.idx] <= pressed_next;
      if (raw_diff) begin
        last_raw[head.idx]    <= head.raw;
        change_time[head.idx] <= head.now_ms;
      end
    end
  end

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (take) begin
      oq[oq_wr] <= res;
    end
  end

  assign empty    = (oq_count == 2'd0);
  assign oq_pop   = pop && !empty;
  assign res_head = oq[oq_rd];

  // Output queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (take) begin
        oq_wr <= !oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= !oq_rd;
      end
      if (take && !oq_pop) begin
        oq_count <= oq_count + 2'd1;
      end else if (oq_pop && !take) begin
        oq_count <= oq_count - 2'd1;
      end
    end
  end

  `QEDD_ASSERT_NEXT(a_phase_kept, take && head.hit, phase_mem[$past(head.idx)] == $past(head.phase))
  `QEDD_ASSERT_IMPL(a_press_follows_raw, take && res.changed, res.pressed == head.raw)
  `QEDD_ASSERT_IMPL(a_miss_quiet, take && !head.hit, (res.step == 2'sd0) && !res.changed && !res.pressed)

endmodule

`default_nettype wire

[sv/quadrature_encoder_detent_decoder_unit.sv]
// A sample taken by the front queue moves on to the output queue, where its result word
// appears and can be popped.
// Throughput: one sample per cycle while neither queue is full, as the back end updates
// the per-encoder state for each item it takes. Holding pop low fills both two-entry queues
// and raises full; after such a stall the input flows again once the first pop frees room.
// Synchronous active-high reset clears encoder state and queues; debounce 15 ms, 4 steps.
`default_nettype none

module quadrature_encoder_detent_decoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [qedd_pkg::IDX_W-1:0]        encoder_index,
  input  wire logic                              phase_a,
  input  wire logic                              phase_b,
  input  wire logic                              button_raw,
  input  wire logic [qedd_pkg::TIME_W-1:0]       now_ms,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [qedd_pkg::NUMBER_W-1:0]          encoder_number,
  output logic signed [qedd_pkg::STEP_W-1:0]     detent_step,
  output logic                                   button_changed,
  output logic                                   button_pressed,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [qedd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [qedd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qedd_pkg::*;

  cfg_t             cfg;
  logic [SPD_W-1:0] steps_in;
  logic             head_valid;
  logic             head_ready;
  item_t            head;
  result_t          res_head;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign steps_in  = cfg_data[SPD_W-1:0];

  // Configuration registers; steps per detent is stored already clamped to 1..8.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= DEBOUNCE_RESET;
      cfg.steps       <= STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_MS: begin
          cfg.debounce_ms <= cfg_data;
        end
        REG_STEPS_PER_DETENT: begin
          if (steps_in < STEPS_MIN) begin
            cfg.steps <= STEPS_MIN;
          end else if (steps_in > STEPS_MAX) begin
            cfg.steps <= STEPS_MAX;
          end else begin
            cfg.steps <= steps_in;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: accepts and classifies samples.
  qedd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .encoder_index (encoder_index),
    .phase_a       (phase_a),
    .phase_b       (phase_b),
    .button_raw    (button_raw),
    .now_ms        (now_ms),
    .head_valid    (head_valid),
    .head_ready    (head_ready),
    .head          (head)
  );

  // Back end: updates encoder state and queues results.
  qedd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .res_head   (res_head)
  );

  assign encoder_number = res_head.number;
  assign detent_step    = res_head.step;
  assign button_changed = res_head.changed;
  assign button_pressed = res_head.pressed;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import qedd_pkg::*;

  // One poll sample as the sender holds it before it is offered to the block.
  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic              a;
    logic              b;
    logic              raw;
    logic [TIME_W-1:0] now;
  } poll_sample_t;

  // Quadrature step for each {old phase, new phase} pair.
  localparam int QUAD_DELTA [16] = '{
     0, -1,  1,  0,
     1,  0,  0, -1,
    -1,  0,  0,  1,
     0,  1, -1,  0
  };

  // Phase order that counts upwards through the table.
  localparam logic [1:0] FORWARD_PHASES [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

  // Register settings for the random phases; the extremes sit among them.
  localparam int PHASES = 9;
  localparam logic [CFG_DATA_W-1:0] PHASE_DEBOUNCE [PHASES] = '{
    8'h0F, 8'h00, 8'hFF, 8'h03, 8'h28, 8'h07, 8'h00, 8'h80, 8'h0F
  };
  localparam logic [CFG_DATA_W-1:0] PHASE_STEPS [PHASES] = '{
    8'h04, 8'h00, 8'hFF, 8'h01, 8'h08, 8'hA2, 8'h59, 8'h03, 8'h04
  };

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [IDX_W-1:0]           encoder_index = '0;
  logic                       phase_a = 1'b0;
  logic                       phase_b = 1'b0;
  logic                       button_raw = 1'b0;
  logic [TIME_W-1:0]          now_ms = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [NUMBER_W-1:0]        encoder_number;
  logic signed [STEP_W-1:0]   detent_step;
  logic                       button_changed;
  logic                       button_pressed;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Samples waiting to be offered, and results owed by the block.
  poll_sample_t poll_backlog [$];
  result_t      pending_reports [$];
  poll_sample_t tx_word;
  int           tx_wait = 0;
  int           rx_wait = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;

  // Decoder state as predicted by the testbench.
  logic [DEB_W-1:0]  cur_debounce = DEBOUNCE_RESET;
  logic [SPD_W-1:0]  cur_steps = STEPS_RESET;
  logic [1:0]        enc_phase [ENCODER_COUNT] = '{default: 2'b00};
  int                enc_acc [ENCODER_COUNT] = '{default: 0};
  logic              btn_stable [ENCODER_COUNT] = '{default: 1'b0};
  logic              btn_last [ENCODER_COUNT] = '{default: 1'b0};
  logic [TIME_W-1:0] btn_time [ENCODER_COUNT] = '{default: '0};

  // Stimulus generator state: position in the phase cycle, direction, button.
  int                gen_pos [ENCODER_COUNT] = '{default: 0};
  int                gen_dir [ENCODER_COUNT] = '{1, -1, 1, -1};
  logic              gen_btn [ENCODER_COUNT] = '{default: 1'b0};
  logic [TIME_W-1:0] gen_now = '0;

  int mismatches = 0;
  int samples_sent = 0;
  int reports_checked = 0;
  int detents_fwd = 0;
  int detents_back = 0;
  int button_edges = 0;

  quadrature_encoder_detent_decoder_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .encoder_index  (encoder_index),
    .phase_a        (phase_a),
    .phase_b        (phase_b),
    .button_raw     (button_raw),
    .now_ms         (now_ms),
    .empty          (empty),
    .pop            (pop),
    .encoder_number (encoder_number),
    .detent_step    (detent_step),
    .button_changed (button_changed),
    .button_pressed (button_pressed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Updates the predicted decoder state with one sample and returns its report.
  function automatic result_t decode_poll(poll_sample_t s);
    result_t           r;
    logic [1:0]        new_phase;
    logic [TIME_W-1:0] elapsed;
    int                limit;
    int                sum;
    r.number  = NUMBER_W'(s.idx) + NUMBER_W'(1);
    r.step    = '0;
    r.changed = 1'b0;
    new_phase = {s.a, s.b};
    // Out-of-range step counts saturate to the nearest legal value.
    if (cur_steps == 0) limit = 1;
    else if (cur_steps > 8) limit = 8;
    else limit = int'(cur_steps);
    sum = enc_acc[s.idx] + QUAD_DELTA[{enc_phase[s.idx], new_phase}];
    enc_phase[s.idx] = new_phase;
    // At most one detent leaves the accumulator per sample.
    if (sum >= limit) begin
      sum -= limit;
      r.step = 2'sd1;
      detents_fwd++;
    end else if (sum <= -limit) begin
      sum += limit;
      r.step = -2'sd1;
      detents_back++;
    end
    enc_acc[s.idx] = sum;
    // Debounce: the raw level must have held for the set time, modulo 2^32.
    if (s.raw != btn_last[s.idx]) begin
      btn_last[s.idx] = s.raw;
      btn_time[s.idx] = s.now;
    end
    elapsed = s.now - btn_time[s.idx];
    if (elapsed >= {{(TIME_W-DEB_W){1'b0}}, cur_debounce} && s.raw != btn_stable[s.idx]) begin
      btn_stable[s.idx] = s.raw;
      r.changed = 1'b1;
      button_edges++;
    end
    r.pressed = btn_stable[s.idx];
    return r;
  endfunction

  // Sender: offers backlog samples, with a random gap drawn for each word.
  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      tx_wait <= 0;
    end else if (!push || !full) begin
      if (push) begin
        pending_reports.push_back(decode_poll(tx_word));
        samples_sent++;
      end
      if (tx_wait != 0) begin
        push    <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (poll_backlog.size() != 0) begin
        tx_word = poll_backlog.pop_front();
        encoder_index <= tx_word.idx;
        phase_a       <= tx_word.a;
        phase_b       <= tx_word.b;
        button_raw    <= tx_word.raw;
        now_ms        <= tx_word.now;
        push          <= 1'b1;
        tx_wait       <= tx_quiet ? 0 : $urandom_range(0, 12);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: takes result words with random stalls and checks each field.
  always @(posedge clk) begin : report_monitor
    result_t want;
    int      stall;
    if (rst) begin
      pop     <= 1'b0;
      rx_wait <= 0;
    end else if (pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word for encoder %0d with nothing expected", $time,
                 encoder_number);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (encoder_number !== want.number) begin
          $display("%0t: encoder_number expected %0d got %0d", $time, want.number,
                   encoder_number);
          mismatches++;
        end
        if (detent_step !== want.step) begin
          $display("%0t: detent_step expected %0d got %0d (encoder %0d)", $time,
                   want.step, detent_step, want.number);
          mismatches++;
        end
        if (button_changed !== want.changed) begin
          $display("%0t: button_changed expected %0b got %0b (encoder %0d)", $time,
                   want.changed, button_changed, want.number);
          mismatches++;
        end
        if (button_pressed !== want.pressed) begin
          $display("%0t: button_pressed expected %0b got %0b (encoder %0d)", $time,
                   want.pressed, button_pressed, want.number);
          mismatches++;
        end
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 12);
      rx_wait <= stall;
      pop     <= (stall == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      pop     <= (rx_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic queue_poll(input int idx, input logic a, input logic b, input logic raw,
                            input logic [TIME_W-1:0] now);
    poll_sample_t s;
    s.idx = IDX_W'(idx);
    s.a   = a;
    s.b   = b;
    s.raw = raw;
    s.now = now;
    poll_backlog.push_back(s);
  endtask

  // Mostly clean rotation with random direction changes, some skipped or
  // repeated phases, button bounce and the odd large jump of the clock.
  task automatic queue_random(input int count);
    int idx;
    int roll;
    for (int n = 0; n < count; n++) begin
      idx  = $urandom_range(0, ENCODER_COUNT - 1);
      roll = $urandom_range(0, 99);
      if (roll < 8) gen_dir[idx] = -gen_dir[idx];
      if (roll < 70) gen_pos[idx] = (gen_pos[idx] + gen_dir[idx] + 4) % 4;
      else if (roll >= 80 && roll < 90) gen_pos[idx] = (gen_pos[idx] + 2) % 4;
      else if (roll >= 90) gen_pos[idx] = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 12) gen_btn[idx] = ~gen_btn[idx];
      gen_now += ($urandom_range(0, 99) < 4) ? $urandom : $urandom_range(0, 9);
      queue_poll(idx, FORWARD_PHASES[gen_pos[idx]][1], FORWARD_PHASES[gen_pos[idx]][0],
                 gen_btn[idx], gen_now);
    end
  endtask

  // Waits until every sample has gone in and every result word has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (poll_backlog.size() != 0 || push || pending_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] which,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == REG_DEBOUNCE_MS) cur_debounce = data;
    else if (which == REG_STEPS_PER_DETENT) cur_steps = data[SPD_W-1:0];
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one detent each way, a skipped phase, button debounce
    // including bounce and a release across the wrap of the clock.
    queue_poll(0, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
    queue_poll(0, 1'b1, 1'b1, 1'b0, 32'h0000_0001);
    queue_poll(0, 1'b0, 1'b1, 1'b0, 32'h0000_0002);
    queue_poll(0, 1'b0, 1'b0, 1'b0, 32'h0000_0003);
    queue_poll(1, 1'b0, 1'b1, 1'b0, 32'h0000_0004);
    queue_poll(1, 1'b1, 1'b1, 1'b0, 32'h0000_0005);
    queue_poll(1, 1'b1, 1'b0, 1'b0, 32'h0000_0006);
    queue_poll(1, 1'b0, 1'b0, 1'b0, 32'h0000_0007);
    queue_poll(2, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
    queue_poll(2, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    queue_poll(3, 1'b0, 1'b0, 1'b1, 32'd100);
    queue_poll(3, 1'b0, 1'b0, 1'b1, 32'd114);
    queue_poll(3, 1'b0, 1'b0, 1'b1, 32'd115);
    queue_poll(3, 1'b0, 1'b0, 1'b0, 32'd200);
    queue_poll(3, 1'b0, 1'b0, 1'b1, 32'd205);
    queue_poll(3, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF8);
    queue_poll(3, 1'b0, 1'b0, 1'b0, 32'h0000_0006);
    queue_poll(3, 1'b0, 1'b0, 1'b0, 32'h0000_0007);
    wait_idle();

    // Build up seven transitions at eight per detent, then drop to one per
    // detent so that several detents are pending and leave one per sample.
    write_reg(REG_STEPS_PER_DETENT, 8'h08);
    @(negedge clk);
    for (int k = 1; k <= 7; k++)
      queue_poll(0, FORWARD_PHASES[k % 4][1], FORWARD_PHASES[k % 4][0], 1'b0, 32'd300);
    wait_idle();
    write_reg(REG_STEPS_PER_DETENT, 8'h01);
    @(negedge clk);
    repeat (3) queue_poll(0, FORWARD_PHASES[3][1], FORWARD_PHASES[3][0], 1'b0, 32'd301);
    wait_idle();

    // Random phases, one register setting each.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_DEBOUNCE_MS, PHASE_DEBOUNCE[ph]);
      write_reg(REG_STEPS_PER_DETENT, PHASE_STEPS[ph]);
      @(negedge clk);
      tx_quiet = (ph == 4 || ph == 6);
      rx_quiet = (ph == 5 || ph == 6);
      for (int e = 0; e < ENCODER_COUNT; e++) gen_pos[e] = 0;
      if (ph == 7) gen_now = 32'hFFFF_FF80;
      if (ph == 8) begin
        // The sender holds back until the block has drained, then resumes.
        queue_random(100);
        wait_idle();
        queue_random(105);
      end else begin
        queue_random(205);
      end
      wait_idle();
    end

    $display("Sent %0d samples over %0d register settings; %0d result words checked.",
             samples_sent, PHASES + 3, reports_checked);
    $display("Predicted %0d forward and %0d backward detents, %0d button edges.",
             detents_fwd, detents_back, button_edges);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #(64'd5_000_000);
    $display("%0t: timed out with %0d result words outstanding", $time,
             pending_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/qedd_pkg.sv
sv/qedd_front.sv
sv/qedd_back.sv
sv/quadrature_encoder_detent_decoder_unit.sv
tb/tb.sv
